### sv/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

   // Address and result field widths.
   localparam int ADDR_W  = 64;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 32;

   // Geometry of the tag store.
   localparam int SET_BITS  = 8;
   localparam int WAY_BITS  = 3;
   localparam int NUM_SETS  = 1 << SET_BITS;
   localparam int NUM_WAYS  = 1 << WAY_BITS;
   localparam int SHIFT_W   = 7;

   // Configuration register widths.
   localparam int SIB_W  = 4;
   localparam int WL_W   = 2;
   localparam int OFB_W  = 6;
   localparam int CSR_DW = 6;
   localparam int CSR_IW = 2;

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] CSR_SET_INDEX_BITS = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_WAYS_LOG2      = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_OFFSET_BITS    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [SIB_W-1:0] SIB_RESET = 4'd4;
   localparam logic [WL_W-1:0]  WL_RESET  = 2'd1;
   localparam logic [OFB_W-1:0] OFB_RESET = 6'd4;

   localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // One memory row holds every way of one set.
   typedef struct packed {
      logic [NUM_WAYS-1:0]                valid;
      logic [NUM_WAYS-1:0][ADDR_W-1:0]    tag;
      logic [NUM_WAYS-1:0][STAMP_W-1:0]   stamp;
   } row_type;

   // Outcome of the way search for one transaction.
   typedef struct packed {
      logic                hit;
      logic                evicted;
      logic [WAY_BITS-1:0] way;
   } sel_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

`default_nettype wire

### sv/sacl_row_ram.sv
`default_nettype none

module sacl_row_ram (
   input  wire                             clock,
   input  wire                             rd_en,
   input  wire  [sacl_pkg::SET_BITS-1:0]   rd_addr,
   output sacl_pkg::row_type               rd_data,
   input  wire                             wr_en,
   input  wire  [sacl_pkg::SET_BITS-1:0]   wr_addr,
   input  sacl_pkg::row_type               wr_data
);
   import sacl_pkg::*;

   row_type mem [NUM_SETS];
   row_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/sacl_way_select.sv
`default_nettype none

module sacl_way_select (
   input  sacl_pkg::row_type               row,
   input  wire  [sacl_pkg::ADDR_W-1:0]     tag,
   input  wire  [sacl_pkg::WL_W-1:0]       ways_log2,
   output sacl_pkg::sel_type               sel
);
   import sacl_pkg::*;

   logic [WAY_BITS:0]   nways;
   logic                hit;
   logic [WAY_BITS-1:0] hit_way;
   logic                empty_found;
   logic [WAY_BITS-1:0] empty_way;
   logic [WAY_BITS-1:0] victim_way;

   logic [STAMP_W-1:0]  l1_stamp [NUM_WAYS/2];
   logic [WAY_BITS-1:0] l1_way   [NUM_WAYS/2];
   logic [STAMP_W-1:0]  l2_stamp [NUM_WAYS/4];
   logic [WAY_BITS-1:0] l2_way   [NUM_WAYS/4];
   logic [WAY_BITS-1:0] l3_way;

   assign nways = (WAY_BITS+1)'(1) << ways_log2;

   // Lowest way in use that holds the tag, and lowest way in use that is free.
   always_comb begin
      hit         = 1'b0;
      hit_way     = '0;
      empty_found = 1'b0;
      empty_way   = '0;
      for (int j = NUM_WAYS - 1; j >= 0; j--) begin
         if (j < int'(nways) && row.valid[j] && row.tag[j] == tag) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(j);
         end
         if (j < int'(nways) && !row.valid[j]) begin
            empty_found = 1'b1;
            empty_way   = WAY_BITS'(j);
         end
      end
   end

   // Oldest-stamp tree; on equal stamps the lower way wins at every node.
   always_comb begin
      for (int i = 0; i < NUM_WAYS / 2; i++) begin
         if (row.stamp[2*i+1] < row.stamp[2*i]) begin
            l1_stamp[i] = row.stamp[2*i+1];
            l1_way[i]   = WAY_BITS'(2*i+1);
         end else begin
            l1_stamp[i] = row.stamp[2*i];
            l1_way[i]   = WAY_BITS'(2*i);
         end
      end
      for (int i = 0; i < NUM_WAYS / 4; i++) begin
         if (l1_stamp[2*i+1] < l1_stamp[2*i]) begin
            l2_stamp[i] = l1_stamp[2*i+1];
            l2_way[i]   = l1_way[2*i+1];
         end else begin
            l2_stamp[i] = l1_stamp[2*i];
            l2_way[i]   = l1_way[2*i];
         end
      end
      if (l2_stamp[1] < l2_stamp[0]) begin
         l3_way = l2_way[1];
      end else begin
         l3_way = l2_way[0];
      end
   end

   // The node covering exactly the ways in use gives the victim.
   always_comb begin
      case (ways_log2)
         2'd0:    victim_way = '0;
         2'd1:    victim_way = l1_way[0];
         2'd2:    victim_way = l2_way[0];
         default: victim_way = l3_way;
      endcase
   end

   always_comb begin
      sel.hit     = hit;
      sel.evicted = !hit && !empty_found;
      if (hit) begin
         sel.way = hit_way;
      end else if (empty_found) begin
         sel.way = empty_way;
      end else begin
         sel.way = victim_way;
      end
   end

endmodule

`default_nettype wire

### sv/set_assoc_cache_lru_lookup.sv
// Set-associative cache lookup with least-recently-used replacement. Each address
// transaction is split into offset, set index and tag by the csr_ registers, and
// one response transaction reports hit or miss, the set, the way hit, filled or
// replaced, whether a valid line was evicted, and saturating hit and miss counts.
// A transaction is accepted in the idle state, where the set's row is read from the
// row memory; in the lookup state the ways are searched and the updated row is
// written back. No new request is taken until the lookup state has written back.
// A response that is not taken holds the lookup state until the output register
// frees. Reset clears one written flag per set at once, so there is no clearing
// pass. Registers should be written only while the block is idle.

`default_nettype none

module set_assoc_cache_lru_lookup (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [sacl_pkg::ADDR_W-1:0]      req_address,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_hit,
   output logic [sacl_pkg::SET_BITS-1:0]    rsp_set_number,
   output logic [sacl_pkg::WAY_BITS-1:0]    rsp_way_used,
   output logic                             rsp_evicted,
   output logic [sacl_pkg::COUNT_W-1:0]     rsp_hit_count,
   output logic [sacl_pkg::COUNT_W-1:0]     rsp_miss_count,
   input  wire                              csr_we,
   input  wire  [sacl_pkg::CSR_IW-1:0]      csr_index,
   input  wire  [sacl_pkg::CSR_DW-1:0]      csr_wdata
);
   import sacl_pkg::*;

   state_type state_ff, state_in;

   logic [SIB_W-1:0] set_index_bits_ff;
   logic [WL_W-1:0]  ways_log2_ff;
   logic [OFB_W-1:0] offset_bits_ff;

   logic [NUM_SETS-1:0] row_written_ff, row_written_in;
   logic                written_ff;
   logic [SET_BITS-1:0] set_ff, set_in;
   logic [ADDR_W-1:0]   tag_ff, tag_in;

   logic [STAMP_W-1:0]  clock_ff, clock_in;
   logic [COUNT_W-1:0]  hits_ff, hits_in;
   logic [COUNT_W-1:0]  misses_ff, misses_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [SET_BITS-1:0] rsp_set_ff;
   logic [WAY_BITS-1:0] rsp_way_ff;
   logic                rsp_evicted_ff;
   logic [COUNT_W-1:0]  rsp_hits_ff;
   logic [COUNT_W-1:0]  rsp_misses_ff;

   logic                accept;
   logic                commit;
   logic [SIB_W-1:0]    sib_eff;
   logic [SET_BITS:0]   set_mask_wide;
   logic [ADDR_W-1:0]   addr_shifted;
   logic [SHIFT_W-1:0]  tag_shift;
   row_type             row_rd;
   row_type             row_cur;
   row_type             row_wr;
   sel_type             sel;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_index_bits_ff <= SIB_RESET;
         ways_log2_ff      <= WL_RESET;
         offset_bits_ff    <= OFB_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_INDEX_BITS: set_index_bits_ff <= csr_wdata[SIB_W-1:0];
            CSR_WAYS_LOG2:      ways_log2_ff      <= csr_wdata[WL_W-1:0];
            CSR_OFFSET_BITS:    offset_bits_ff    <= csr_wdata[OFB_W-1:0];
            default:            ;
         endcase
      end
   end

   // Address split; shifts past the top of the address give zero.
   always_comb begin
      sib_eff       = (set_index_bits_ff > SIB_W'(SET_BITS)) ? SIB_W'(SET_BITS)
                                                             : set_index_bits_ff;
      set_mask_wide = ((SET_BITS+1)'(1) << sib_eff) - (SET_BITS+1)'(1);
      addr_shifted  = req_address >> offset_bits_ff;
      set_in        = addr_shifted[SET_BITS-1:0] & set_mask_wide[SET_BITS-1:0];
      tag_shift     = SHIFT_W'(offset_bits_ff) + SHIFT_W'(sib_eff);
      tag_in        = req_address >> tag_shift;
   end

   // Next state.
   always_comb begin
      case (state_ff)
         ST_IDLE:   state_in = (req_valid) ? ST_LOOKUP : ST_IDLE;
         ST_LOOKUP: state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_LOOKUP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            commit    = 1'b0;
         end
         ST_LOOKUP: begin
            req_ready = 1'b0;
            commit    = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
            commit    = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   sacl_row_ram u_row_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (set_in),
      .rd_data (row_rd),
      .wr_en   (commit),
      .wr_addr (set_ff),
      .wr_data (row_wr)
   );

   // A row never written since reset has no valid ways.
   always_comb begin
      row_cur       = row_rd;
      row_cur.valid = written_ff ? row_rd.valid : '0;
   end

   sacl_way_select u_way_select (
      .row       (row_cur),
      .tag       (tag_ff),
      .ways_log2 (ways_log2_ff),
      .sel       (sel)
   );

   // Saturating access clock and counters for the transaction in lookup.
   always_comb begin
      clock_in  = (clock_ff == STAMP_MAX) ? clock_ff : clock_ff + STAMP_W'(1);
      hits_in   = hits_ff;
      misses_in = misses_ff;
      if (sel.hit) begin
         hits_in = (hits_ff == COUNT_MAX) ? hits_ff : hits_ff + COUNT_W'(1);
      end else begin
         misses_in = (misses_ff == COUNT_MAX) ? misses_ff : misses_ff + COUNT_W'(1);
      end
   end

   // Updated row: refresh the stamp on a hit, install the tag on a miss.
   always_comb begin
      row_wr                  = row_cur;
      row_wr.valid[sel.way]   = 1'b1;
      row_wr.tag[sel.way]     = tag_ff;
      row_wr.stamp[sel.way]   = clock_in;
      row_written_in          = row_written_ff;
      row_written_in[set_ff]  = 1'b1;
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_written_ff <= '0;
         clock_ff       <= '0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            row_written_ff <= row_written_in;
            clock_ff       <= clock_in;
            hits_ff        <= hits_in;
            misses_ff      <= misses_in;
         end
      end
   end

   // Transaction payload captured at accept.
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff     <= set_in;
         tag_ff     <= tag_in;
         written_ff <= row_written_ff[set_in];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff     <= sel.hit;
         rsp_set_ff     <= set_ff;
         rsp_way_ff     <= sel.way;
         rsp_evicted_ff <= sel.evicted;
         rsp_hits_ff    <= hits_in;
         rsp_misses_ff  <= misses_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_set_number = rsp_set_ff;
   assign rsp_way_used   = rsp_way_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_hit_count  = rsp_hits_ff;
   assign rsp_miss_count = rsp_misses_ff;

endmodule

`default_nettype wire
